// ----- rtl/b2nv_pkg.sv -----
`timescale 1ns / 1ps

package b2nv_pkg;

   // Frame limits
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   // Line store of top-row pair sums, one entry per horizontal pair
   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int IDX_W      = $clog2(LINE_DEPTH);

   // Position counters
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   // Configuration registers
   localparam int DIM_W        = 12;
   localparam int WIDTH_RESET  = 1920;
   localparam int HEIGHT_RESET = 1080;

   // Component and pair-sum widths
   localparam int PIX_W  = 8;
   localparam int PAIR_W = PIX_W + 1;
   localparam int QUAD_W = PIX_W + 2;
   localparam int SUMS_W = 3 * PAIR_W;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Three component sums of one horizontal pair
   typedef struct packed {
      logic [PAIR_W-1:0] red;
      logic [PAIR_W-1:0] green;
      logic [PAIR_W-1:0] blue;
   } pair_sums_type;

   // Floor-shift a chroma product sum by 8, add the 128 offset, clamp to a byte
   function automatic logic [PIX_W-1:0] chroma_byte(input logic [15:0] pos,
                                                    input logic [15:0] neg);
      logic signed [16:0] diff;
      logic signed [9:0]  val;
      diff = $signed({1'b0, pos}) - $signed({1'b0, neg});
      val  = 10'(diff >>> 8) + 10'sd128;
      if (val < 10'sd0) begin
         chroma_byte = '0;
      end else if (val > 10'sd255) begin
         chroma_byte = '1;
      end else begin
         chroma_byte = val[PIX_W-1:0];
      end
   endfunction

endpackage

// ----- rtl/b2nv_ram.sv -----
`timescale 1ns / 1ps

module b2nv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Write port and registered read port; read data holds between reads
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ----- rtl/bgra_to_nv12_converter_core.sv -----
`timescale 1ns / 1ps

// BGR pixel stream to NV12 (BT.601 limited range) converter.
// req_* channel: one pixel per item (blue, green, red) in raster order over a
// frame of csr frame_width x frame_height pixels. rsp_* channel: one item per
// pixel carrying its luma, frame_end on the last pixel of the frame, and on
// the pixel that completes a 2x2 block also chroma_valid with Cb/Cr taken
// from the block's averaged color (Cb/Cr read 0 otherwise). An odd last
// column or row reuses its edge pixels.
// There are 3 register stages: stage 1, stage 2 and the output register.
// One item per cycle is taken and given while rsp_stall is low; each pixel
// makes at most one line store access (a write on even rows, a read on odd
// rows). Each stage holds its item when the next one is full and not moving,
// so a stall on rsp_stall fills the pipeline bubbles first and then reaches
// req_stall combinationally.
// csr_write with csr_index 0/1 sets frame_width/frame_height; write only while
// idle. Reset returns the frame position to the origin and the sizes to
// 1920x1080 and empties the pipeline. The line store needs no clearing: an
// entry is always written on an even row before the odd row reads it.
module bgra_to_nv12_converter_core (
   input  logic                          clock,
   input  logic                          reset,
   // Configuration
   input  logic                          csr_write,
   input  logic [0:0]                    csr_index,
   input  logic [b2nv_pkg::DIM_W-1:0]    csr_data,
   // Pixel input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [b2nv_pkg::PIX_W-1:0]    req_blue,
   input  logic [b2nv_pkg::PIX_W-1:0]    req_green,
   input  logic [b2nv_pkg::PIX_W-1:0]    req_red,
   // Result output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [b2nv_pkg::PIX_W-1:0]    rsp_luma,
   output logic                          rsp_chroma_valid,
   output logic [b2nv_pkg::PIX_W-1:0]    rsp_chroma_blue,
   output logic [b2nv_pkg::PIX_W-1:0]    rsp_chroma_red,
   output logic                          rsp_frame_end
);

   localparam int PIX_W  = b2nv_pkg::PIX_W;
   localparam int QUAD_W = b2nv_pkg::QUAD_W;
   localparam int DIM_W  = b2nv_pkg::DIM_W;
   localparam int COL_W  = b2nv_pkg::COL_W;
   localparam int ROW_W  = b2nv_pkg::ROW_W;
   localparam int IDX_W  = b2nv_pkg::IDX_W;

   // Configuration registers
   logic [DIM_W-1:0] frame_width_ff, frame_height_ff;

   // Frame position and held even-column pixel
   logic [COL_W-1:0] column_count_ff, column_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic [PIX_W-1:0] held_blue_ff, held_green_ff, held_red_ff;

   // Stage 1: pair sums and pixel for luma
   logic                      s1_valid_ff;
   b2nv_pkg::pair_sums_type   s1_sums_ff;
   logic                      s1_block_ff, s1_row_odd_ff, s1_frame_end_ff;
   logic [PIX_W-1:0]          s1_blue_ff, s1_green_ff, s1_red_ff;

   // Stage 2: block averages and luma
   logic                      s2_valid_ff;
   logic                      s2_block_ff, s2_frame_end_ff;
   logic [PIX_W-1:0]          s2_avg_blue_ff, s2_avg_green_ff, s2_avg_red_ff;
   logic [PIX_W-1:0]          s2_luma_ff;

   // Output register
   logic                      out_valid_ff;
   logic [PIX_W-1:0]          out_luma_ff, out_cb_ff, out_cr_ff;
   logic                      out_chroma_valid_ff, out_frame_end_ff;

   // Handshake and stage enables
   logic out_en, s2_en, s1_en, accept;

   // Stage 0 decode
   logic [DIM_W-1:0]          width_eff, height_eff;
   logic                      last_col, last_row, col_odd, row_odd;
   logic                      pair_done;
   b2nv_pkg::pair_sums_type   pair_sums;
   logic                      line_write, line_read;
   logic [IDX_W-1:0]          line_index;
   logic [b2nv_pkg::SUMS_W-1:0] line_read_data;
   b2nv_pkg::pair_sums_type   top_sums;

   // Stage 1 compute
   logic [QUAD_W-1:0] quad_blue, quad_green, quad_red;
   logic [15:0]       luma_sum;

   // Stage 2 compute
   logic [15:0]       cb_pos, cb_neg, cr_pos, cr_neg;

   // ---------------------------------------------------------------------
   // Pipeline flow: each stage advances when the next one is empty or moving
   assign out_en    = !out_valid_ff || !rsp_stall;
   assign s2_en     = !s2_valid_ff || out_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_stall = !s1_en;
   assign accept    = req_valid && s1_en;

   // ---------------------------------------------------------------------
   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_W'(b2nv_pkg::WIDTH_RESET);
         frame_height_ff <= DIM_W'(b2nv_pkg::HEIGHT_RESET);
      end else if (csr_write) begin
         unique case (b2nv_pkg::csr_index_type'(csr_index))
            b2nv_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            b2nv_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Saturate the frame size to 1..max
   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = DIM_W'(1);
      end else if (frame_width_ff > DIM_W'(b2nv_pkg::MAX_WIDTH)) begin
         width_eff = DIM_W'(b2nv_pkg::MAX_WIDTH);
      end else begin
         width_eff = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         height_eff = DIM_W'(1);
      end else if (frame_height_ff > DIM_W'(b2nv_pkg::MAX_HEIGHT)) begin
         height_eff = DIM_W'(b2nv_pkg::MAX_HEIGHT);
      end else begin
         height_eff = frame_height_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 0: position decode, pair sums, line store access
   assign last_col   = (DIM_W'(column_count_ff) + DIM_W'(1)) >= width_eff;
   assign last_row   = (DIM_W'(row_count_ff) + DIM_W'(1)) >= height_eff;
   assign col_odd    = column_count_ff[0];
   assign row_odd    = row_count_ff[0];
   assign pair_done  = col_odd || last_col;
   assign line_index = column_count_ff[COL_W-1:1];

   always_comb begin
      if (col_odd) begin
         pair_sums.blue  = {1'b0, held_blue_ff}  + {1'b0, req_blue};
         pair_sums.green = {1'b0, held_green_ff} + {1'b0, req_green};
         pair_sums.red   = {1'b0, held_red_ff}   + {1'b0, req_red};
      end else begin
         // Odd last column: pair the pixel with itself
         pair_sums.blue  = {req_blue, 1'b0};
         pair_sums.green = {req_green, 1'b0};
         pair_sums.red   = {req_red, 1'b0};
      end
   end

   // Store top-row pair sums unless the even row is also the last row
   assign line_write = accept && pair_done && !row_odd && !last_row;
   assign line_read  = accept && pair_done && row_odd;

   b2nv_ram #(
      .WIDTH(b2nv_pkg::SUMS_W),
      .DEPTH(b2nv_pkg::LINE_DEPTH)
   ) u_line_store (
      .clock         (clock),
      .write_enable  (line_write),
      .write_address (line_index),
      .write_data    (pair_sums),
      .read_enable   (line_read),
      .read_address  (line_index),
      .read_data     (line_read_data)
   );

   // Advance position and hold the even-column pixel
   always_comb begin
      if (last_col) begin
         column_count_in = '0;
         row_count_in    = last_row ? '0 : row_count_ff + ROW_W'(1);
      end else begin
         column_count_in = column_count_ff + COL_W'(1);
         row_count_in    = row_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         held_blue_ff    <= '0;
         held_green_ff   <= '0;
         held_red_ff     <= '0;
      end else if (accept) begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         if (!col_odd && !last_col) begin
            held_blue_ff  <= req_blue;
            held_green_ff <= req_green;
            held_red_ff   <= req_red;
         end
      end
   end

   // Stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sums_ff      <= pair_sums;
         s1_block_ff     <= pair_done && (row_odd || last_row);
         s1_row_odd_ff   <= row_odd;
         s1_frame_end_ff <= last_col && last_row;
         s1_blue_ff      <= req_blue;
         s1_green_ff     <= req_green;
         s1_red_ff       <= req_red;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: block sums, averages and luma
   assign top_sums = b2nv_pkg::pair_sums_type'(line_read_data);

   always_comb begin
      if (s1_row_odd_ff) begin
         quad_blue  = {1'b0, s1_sums_ff.blue}  + {1'b0, top_sums.blue};
         quad_green = {1'b0, s1_sums_ff.green} + {1'b0, top_sums.green};
         quad_red   = {1'b0, s1_sums_ff.red}   + {1'b0, top_sums.red};
      end else begin
         // Odd last row: double the pair sums
         quad_blue  = {s1_sums_ff.blue, 1'b0};
         quad_green = {s1_sums_ff.green, 1'b0};
         quad_red   = {s1_sums_ff.red, 1'b0};
      end
   end

   assign luma_sum = 16'd66 * {8'd0, s1_red_ff} + 16'd129 * {8'd0, s1_green_ff}
                   + 16'd25 * {8'd0, s1_blue_ff} + 16'd128;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Luma never exceeds 235, so no clamp is needed
   always_ff @(posedge clock) begin
      if (s2_en && s1_valid_ff) begin
         s2_block_ff     <= s1_block_ff;
         s2_frame_end_ff <= s1_frame_end_ff;
         s2_avg_blue_ff  <= quad_blue[QUAD_W-1:2];
         s2_avg_green_ff <= quad_green[QUAD_W-1:2];
         s2_avg_red_ff   <= quad_red[QUAD_W-1:2];
         s2_luma_ff      <= luma_sum[15:8] + PIX_W'(16);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: chroma products
   assign cb_pos = 16'd112 * {8'd0, s2_avg_blue_ff} + 16'd128;
   assign cb_neg = 16'd38 * {8'd0, s2_avg_red_ff} + 16'd74 * {8'd0, s2_avg_green_ff};
   assign cr_pos = 16'd112 * {8'd0, s2_avg_red_ff} + 16'd128;
   assign cr_neg = 16'd94 * {8'd0, s2_avg_green_ff} + 16'd18 * {8'd0, s2_avg_blue_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_en) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   // Zero chroma unless the item completes a block
   always_ff @(posedge clock) begin
      if (out_en && s2_valid_ff) begin
         out_luma_ff         <= s2_luma_ff;
         out_chroma_valid_ff <= s2_block_ff;
         out_frame_end_ff    <= s2_frame_end_ff;
         out_cb_ff <= s2_block_ff ? b2nv_pkg::chroma_byte(cb_pos, cb_neg) : '0;
         out_cr_ff <= s2_block_ff ? b2nv_pkg::chroma_byte(cr_pos, cr_neg) : '0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_luma         = out_luma_ff;
   assign rsp_chroma_valid = out_chroma_valid_ff;
   assign rsp_chroma_blue  = out_cb_ff;
   assign rsp_chroma_red   = out_cr_ff;
   assign rsp_frame_end    = out_frame_end_ff;

endmodule
